// ----- hw/rtl/spr_pkg.sv -----
// spr_pkg: shared types, constants and register codes for the stream pattern
// replace/pad block. No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package spr_pkg;

  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned LenW    = 5;   // width of the length registers
  localparam int unsigned CntW    = $clog2(MaxPatternBytes + 1);
  localparam int unsigned IdxW    = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned HitW    = 16;
  localparam int unsigned InDataW  = 8;   // data_byte
  localparam int unsigned OutDataW = 24;  // out_byte, hit_count

  localparam logic [7:0]      PadByte = 8'h20;
  localparam logic [HitW-1:0] HitMax  = {HitW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_REPL_LOW     = 3'd3,
    REG_REPL_HIGH    = 3'd4,
    REG_REPL_LEN     = 3'd5
  } cfg_reg_e;

  typedef logic [MaxPatternBytes-1:0][7:0] win_t;
  typedef logic [CntW-1:0]                 cnt_t;

  // Decoded configuration handed from the register file to the window.
  typedef struct packed {
    win_t pattern;
    win_t replacement;
    cnt_t plen;     // clamped pattern length
    cnt_t rlen;     // clamped replacement length
    logic bypass;   // empty pattern or replacement too long
    logic err;      // replacement longer than pattern
  } cfg_t;

  // Shift the window one byte toward index 0; the top entry keeps its value.
  function automatic win_t shift_win(input win_t src);
    win_t sh;
    sh = src;
    for (int i = 0; i < int'(MaxPatternBytes) - 1; i++) begin
      sh[i] = src[i+1];
    end
    return sh;
  endfunction

endpackage

// ----- hw/rtl/spr_cfg_regs.sv -----
// spr_cfg_regs: configuration register file and decode of pattern/replacement.
// Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [spr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spr_pkg::CfgDataW-1:0] cfg_data_i,
  output spr_pkg::cfg_t                cfg_o,
  output logic                         clear_o
);
  import spr_pkg::*;

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [LenW-1:0]     pat_len_q, rep_len_q;
  logic                known_idx;
  logic [2*CfgDataW-1:0] pat_all, rep_all;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (cfg_reg_e'(cfg_index_i))
      REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LEN,
      REG_REPL_LOW, REG_REPL_HIGH, REG_REPL_LEN: known_idx = 1'b1;
      default: known_idx = 1'b0;
    endcase
  end

  // Any write to a defined register discards the string in progress.
  assign clear_o = cfg_valid_i && known_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      pat_len_q <= '0;
      rep_len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LOW:  pat_lo_q  <= cfg_data_i;
        REG_PATTERN_HIGH: pat_hi_q  <= cfg_data_i;
        REG_PATTERN_LEN:  pat_len_q <= cfg_data_i[LenW-1:0];
        REG_REPL_LOW:     rep_lo_q  <= cfg_data_i;
        REG_REPL_HIGH:    rep_hi_q  <= cfg_data_i;
        REG_REPL_LEN:     rep_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};
  assign rep_all = {rep_hi_q, rep_lo_q};

  always_comb begin
    cfg_o.pattern     = pat_all[MaxPatternBytes*8-1:0];
    cfg_o.replacement = rep_all[MaxPatternBytes*8-1:0];
    cfg_o.err         = rep_len_q > pat_len_q;
    cfg_o.bypass      = (pat_len_q == '0) || cfg_o.err;
    // Clamp to the window size; the replacement never exceeds the pattern.
    if (pat_len_q > LenW'(MaxPatternBytes)) begin
      cfg_o.plen = CntW'(MaxPatternBytes);
    end else begin
      cfg_o.plen = pat_len_q[CntW-1:0];
    end
    if (rep_len_q > LenW'(cfg_o.plen)) begin
      cfg_o.rlen = cfg_o.plen;
    end else begin
      cfg_o.rlen = rep_len_q[CntW-1:0];
    end
  end

endmodule

// ----- hw/rtl/spr_in_stage.sv -----
// spr_in_stage: input register of the byte stream.
// Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [spr_pkg::InDataW-1:0] s_data_i,
  input  logic                        s_last_i,
  output logic                        item_valid_o,
  input  logic                        item_take_i,
  output logic [7:0]                  item_byte_o,
  output logic                        item_last_o
);
  import spr_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  assign s_ready_o    = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;
  assign item_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= s_data_i[7:0];
      last_q <= s_last_i;
    end
  end

endmodule

// ----- hw/rtl/spr_window.sv -----
// spr_window: delay line, pattern compare/replace, end-of-string flush and
// output register. Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spr_pkg::cfg_t                cfg_i,
  input  logic                         clear_i,
  input  logic                         item_valid_i,
  output logic                         item_take_o,
  input  logic [7:0]                   item_byte_i,
  input  logic                         item_last_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [spr_pkg::OutDataW-1:0] m_data_o,
  output logic                         m_last_o,
  output logic                         m_user_o
);
  import spr_pkg::*;

  win_t            dl_q, dl_d;
  cnt_t            fill_q, fill_d, blocked_q, blocked_d;
  logic [HitW-1:0] hits_q, hits_d;
  logic            flush_q, flush_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;
  logic [HitW-1:0] out_hits_q, out_hits_d;
  logic            out_err_q, out_err_d;

  logic            adv;
  cnt_t            fc, fc1;
  win_t            win, win_r;
  logic            full, match, hit;
  logic [HitW-1:0] hits_inc;

  assign adv         = !out_valid_q || m_ready_i;
  assign item_take_o = item_valid_i && adv && !flush_q;

  // Window after inserting the new byte, compared and rewritten.
  always_comb begin
    fc = (fill_q >= cfg_i.plen) ? cfg_i.plen - 1'b1 : fill_q;
    fc1 = fc + 1'b1;
    win = dl_q;
    win[fc[IdxW-1:0]] = item_byte_i;
    full = (fc1 == cfg_i.plen);
    match = 1'b1;
    for (int i = 0; i < int'(MaxPatternBytes); i++) begin
      if ((CntW'(i) < cfg_i.plen) && (win[i] != cfg_i.pattern[i])) begin
        match = 1'b0;
      end
    end
    hit = full && (blocked_q == '0) && match;
    win_r = win;
    for (int i = 0; i < int'(MaxPatternBytes); i++) begin
      if (hit && (CntW'(i) < cfg_i.plen)) begin
        win_r[i] = (CntW'(i) < cfg_i.rlen) ? cfg_i.replacement[i] : PadByte;
      end
    end
    hits_inc = (hit && (hits_q != HitMax)) ? hits_q + 1'b1 : hits_q;
  end

  always_comb begin
    dl_d        = dl_q;
    fill_d      = fill_q;
    blocked_d   = blocked_q;
    hits_d      = hits_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_hits_d  = out_hits_q;
    out_err_d   = out_err_q;

    if (clear_i) begin
      fill_d    = '0;
      blocked_d = '0;
      hits_d    = '0;
      flush_d   = 1'b0;
    end else if (flush_q) begin
      if (adv) begin
        out_valid_d = 1'b1;
        out_byte_d  = dl_q[0];
        out_last_d  = (fill_q == cnt_t'(1));
        out_hits_d  = (fill_q == cnt_t'(1)) ? hits_q : '0;
        out_err_d   = 1'b0;
        dl_d        = shift_win(dl_q);
        fill_d      = fill_q - 1'b1;
        if (fill_q == cnt_t'(1)) begin
          flush_d   = 1'b0;
          blocked_d = '0;
          hits_d    = '0;
        end
      end
    end else if (item_take_o) begin
      if (cfg_i.bypass) begin
        out_valid_d = 1'b1;
        out_byte_d  = item_byte_i;
        out_last_d  = item_last_i;
        out_hits_d  = '0;
        out_err_d   = cfg_i.err;
        fill_d      = '0;
        blocked_d   = '0;
        hits_d      = '0;
      end else if (item_last_i) begin
        out_valid_d = 1'b1;
        out_byte_d  = win_r[0];
        out_last_d  = (fc1 == cnt_t'(1));
        out_hits_d  = (fc1 == cnt_t'(1)) ? hits_inc : '0;
        out_err_d   = 1'b0;
        blocked_d   = '0;
        if (fc1 == cnt_t'(1)) begin
          fill_d = '0;
          hits_d = '0;
        end else begin
          dl_d    = shift_win(win_r);
          fill_d  = fc1 - 1'b1;
          hits_d  = hits_inc;
          flush_d = 1'b1;
        end
      end else if (full) begin
        out_valid_d = 1'b1;
        out_byte_d  = win_r[0];
        out_last_d  = 1'b0;
        out_hits_d  = '0;
        out_err_d   = 1'b0;
        dl_d        = shift_win(win_r);
        fill_d      = fc1 - 1'b1;
        hits_d      = hits_inc;
        if (hit) begin
          blocked_d = cfg_i.plen - 1'b1;
        end else if (blocked_q != '0) begin
          blocked_d = blocked_q - 1'b1;
        end
      end else begin
        dl_d   = win;
        fill_d = fc1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      blocked_q   <= '0;
      hits_q      <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      blocked_q   <= blocked_d;
      hits_q      <= hits_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q       <= dl_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_hits_q <= out_hits_d;
    out_err_q  <= out_err_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {out_hits_q, out_byte_q};
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_err_q;

endmodule

// ----- hw/rtl/stream_pattern_replace_pad_core.sv -----
// Streaming find-and-replace with space padding. A byte is registered on
// acceptance and its result byte is registered in the output register; bytes
// trail the input by pattern_len - 1 items. Throughput: one byte per cycle while
// the output is ready; the window drains after a last byte before taking more.
// Reset (rst_ni low, asynchronous) clears the configuration registers, counters
// and valid flags; window and output data registers are not reset.
// Depends on spr_pkg, spr_cfg_regs, spr_in_stage and spr_window.
`timescale 1ns / 1ps

module stream_pattern_replace_pad_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [spr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spr_pkg::CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [spr_pkg::InDataW-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic                         s_axis_tlast_i,   // last_byte
  // Output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [spr_pkg::OutDataW-1:0] m_axis_tdata_o,   // [7:0] out_byte, [23:8] hit_count
  output logic                         m_axis_tlast_o,   // out_last
  output logic                         m_axis_tuser_o    // [0] config_error
);
  import spr_pkg::*;

  cfg_t       cfg;
  logic       cfg_clear;
  logic       item_valid;
  logic       item_take;
  logic [7:0] item_byte;
  logic       item_last;

  // Register file: a write to a defined register also drops the string in
  // progress, so pending window bytes are discarded.
  spr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clear_o     (cfg_clear)
  );

  // Input register: hold the accepted transaction until the window takes it.
  spr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_byte_o  (item_byte),
    .item_last_o  (item_last)
  );

  // Window: insert the byte, compare all pattern bytes at once, rewrite a hit
  // with replacement plus padding, advance the oldest byte into the output
  // register, and drain the window after the last byte of a string; in bypass, bytes pass through.
  spr_window u_win (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clear_i      (cfg_clear),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_byte_i  (item_byte),
    .item_last_i  (item_last),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o),
    .m_user_o     (m_axis_tuser_o)
  );

endmodule
